[rtl/mtac_pkg.sv]
// ----------------------------------------------------------------------------
// mtac_pkg
// Shared types, codes and widths of the musical time arithmetic converter.
// ----------------------------------------------------------------------------
package mtac_pkg;

   localparam int BEATS_W  = 32;
   localparam int REM_W    = 16;   // beat unit is 2**REM_W
   localparam int FRAME_W  = 31;
   localparam int TEMPO_W  = 32;
   localparam int RATE_W   = 20;
   localparam int RATE60_W = 26;
   localparam int Q_W      = 47;   // quotient bits, one divider cell each
   localparam int R_W      = 32;   // partial remainder

   localparam logic [2:0] REQ_CMP = 3'd0;
   localparam logic [2:0] REQ_ADD = 3'd1;
   localparam logic [2:0] REQ_SUB = 3'd2;
   localparam logic [2:0] REQ_TTF = 3'd3;
   localparam logic [2:0] REQ_FTT = 3'd4;

   localparam logic [1:0] ORD_EQ = 2'd0;
   localparam logic [1:0] ORD_LT = 2'd1;
   localparam logic [1:0] ORD_GT = 2'd2;

   localparam logic CSR_TEMPO = 1'b0;
   localparam logic CSR_RATE  = 1'b1;

   localparam logic [TEMPO_W-1:0]  TEMPO_RESET  = 32'd7864320;
   localparam logic [RATE60_W-1:0] RATE60_RESET = 26'd2880000;

   localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
   localparam logic [BEATS_W-1:0] BEATS_MAX = 32'h7FFF_FFFF;
   localparam logic [REM_W-1:0]   REM_MAX   = '1;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [BEATS_W-1:0] a_beats;
      logic [REM_W-1:0]   a_rem;
      logic [BEATS_W-1:0] b_beats;
      logic [REM_W-1:0]   b_rem;
      logic [FRAME_W-1:0] frame_count;
   } req_item_type;

   typedef struct packed {
      logic [BEATS_W-1:0] res_beats;
      logic [REM_W-1:0]   res_rem;
      logic [FRAME_W-1:0] frames_out;
      logic [1:0]         order;
      logic               range_flag;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]     op;
      logic           div;
      logic [R_W-1:0] d;
      logic [R_W-1:0] r;
      logic [Q_W-1:0] sh;
      rsp_item_type   res;
   } cell_data_type;

   // frames per minute from frames per second
   function automatic logic [RATE60_W-1:0] rate_x60(input logic [RATE_W-1:0] x);
      logic [RATE60_W-1:0] w;
      w = {6'b0, x};
      return (w << 6) - (w << 2);
   endfunction

endpackage

[rtl/musical_time_arith_converter.sv]
// ----------------------------------------------------------------------------
// musical_time_arith_converter
// Compare, add and subtract of beat times, and exact conversions between
// beat times and sample frames through a row of divider cells.
//
//   channel | ports              | moves
//   --------+--------------------+---------------------------------
//   request | req_valid/req_ready | operation and operands
//   result  | rsp_valid/rsp_ready | one result per request
//   config  | csr_we/csr_index   | tempo and sample rate writes
//
// one request per cycle while no result is held; each passes two front stages,
// 47 divider cells (one quotient bit each) and the output register.
// every request runs the full row, whatever its operation.
// reset is synchronous; it clears the valid bits and loads the tempo and
// rate defaults, the data registers are left as they are.
// a held result stalls the whole row; req_ready falls with it.
// ----------------------------------------------------------------------------
module musical_time_arith_converter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mtac_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mtac_pkg::rsp_item_type        rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [mtac_pkg::TEMPO_W-1:0]  csr_wdata
);
   import mtac_pkg::*;

   logic [TEMPO_W-1:0]  tempo_ff, tempo_in;
   logic [RATE60_W-1:0] rate60_ff, rate60_in;
   logic                en;
   logic                chain_valid [Q_W+1];
   cell_data_type       chain_data  [Q_W+1];
   logic                out_valid_ff;
   logic [2:0]          out_op_ff;
   rsp_item_type        out_ff, out_in;
   cell_data_type       last;

   always_comb begin
      tempo_in  = tempo_ff;
      rate60_in = rate60_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TEMPO: tempo_in  = csr_wdata;
            CSR_RATE:  rate60_in = rate_x60(csr_wdata[RATE_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff  <= TEMPO_RESET;
         rate60_ff <= RATE60_RESET;
      end else begin
         tempo_ff  <= tempo_in;
         rate60_ff <= rate60_in;
      end
   end

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   mtac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .req        (req_data),
      .tempo      (tempo_ff),
      .rate60     (rate60_ff),
      .head_valid (chain_valid[0]),
      .head       (chain_data[0])
   );

   for (genvar i = 0; i < Q_W; i++) begin : g_cell
      mtac_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   always_comb begin
      last   = chain_data[Q_W];
      out_in = last.res;
      if (last.div) begin
         case (last.op)
            REQ_TTF: out_in.frames_out = last.sh[Q_W-1:REM_W];
            REQ_FTT: begin
               out_in.res_beats = {1'b0, last.sh[Q_W-1:REM_W]};
               out_in.res_rem   = last.sh[REM_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= chain_valid[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff    <= out_in;
         out_op_ff <= last.op;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_order_cmp_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_op_ff != REQ_CMP |-> rsp_data.order == ORD_EQ)
      else $error("order set on a non-compare result");

   a_flag_conv_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_flag |-> out_op_ff == REQ_TTF || out_op_ff == REQ_FTT)
      else $error("range flag on an arithmetic result");

   a_ftt_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_op_ff == REQ_FTT && rsp_data.range_flag
      |-> rsp_data.res_beats == BEATS_MAX && rsp_data.res_rem == REM_MAX)
      else $error("saturated frames to time result not at maximum");

   a_ttf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_op_ff == REQ_TTF && rsp_data.range_flag && rsp_data.frames_out != '0
      |-> rsp_data.frames_out == FRAME_MAX)
      else $error("flagged time to frames result not saturated");

endmodule

[rtl/mtac_front.sv]
// ----------------------------------------------------------------------------
// mtac_front
// Time arithmetic, conversion products and range checks ahead of the divider.
// ----------------------------------------------------------------------------
module mtac_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  mtac_pkg::req_item_type         req,
   input  logic [mtac_pkg::TEMPO_W-1:0]   tempo,
   input  logic [mtac_pkg::RATE60_W-1:0]  rate60,
   output logic                           head_valid,
   output mtac_pkg::cell_data_type        head
);
   import mtac_pkg::*;

   logic                a_valid_ff;
   logic [2:0]          a_op_ff, a_op_in;
   rsp_item_type        a_res_ff, a_res_in;
   logic [62:0]         a_prod_ff, a_prod_in;
   logic [41:0]         a_prod_rem_ff, a_prod_rem_in;
   logic                a_neg_ff;
   logic                b_valid_ff;
   cell_data_type       b_data_ff, b_data_in;

   logic                is_ttf, lt, gt, beq;
   logic [REM_W:0]      sum_rem, diff_rem;
   logic [31:0]         ma, mb;
   logic [63:0]         prod_full;
   logic [78:0]         ttf_num;
   logic [47:0]         nhigh;
   logic [Q_W-1:0]      low;
   logic [R_W-1:0]      d;
   logic                sat;

   always_comb begin
      is_ttf   = (req.req_type == REQ_TTF);
      beq      = (req.a_beats == req.b_beats);
      lt       = ($signed(req.a_beats) < $signed(req.b_beats)) || (beq && req.a_rem < req.b_rem);
      gt       = ($signed(req.a_beats) > $signed(req.b_beats)) || (beq && req.a_rem > req.b_rem);
      sum_rem  = {1'b0, req.a_rem} + {1'b0, req.b_rem};
      diff_rem = {1'b0, req.a_rem} - {1'b0, req.b_rem};
      a_op_in  = req.req_type;
      a_res_in = '0;
      case (req.req_type)
         REQ_CMP: a_res_in.order = lt ? ORD_LT : (gt ? ORD_GT : ORD_EQ);
         REQ_ADD: begin
            a_res_in.res_beats = req.a_beats + req.b_beats + {31'b0, sum_rem[REM_W]};
            a_res_in.res_rem   = sum_rem[REM_W-1:0];
         end
         REQ_SUB: begin
            a_res_in.res_beats = req.a_beats - req.b_beats - {31'b0, diff_rem[REM_W]};
            a_res_in.res_rem   = diff_rem[REM_W-1:0];
         end
         default: ;
      endcase
      // beats times frames per minute, or frames times tempo
      ma            = is_ttf ? {1'b0, req.a_beats[30:0]} : {1'b0, req.frame_count};
      mb            = is_ttf ? {6'b0, rate60} : tempo;
      prod_full     = ma * mb;
      a_prod_in     = prod_full[62:0];
      a_prod_rem_in = req.a_rem * rate60;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff       <= a_op_in;
         a_res_ff      <= a_res_in;
         a_prod_ff     <= a_prod_in;
         a_prod_rem_ff <= a_prod_rem_in;
         a_neg_ff      <= req.a_beats[BEATS_W-1];
      end
   end

   always_comb begin
      ttf_num = {a_prod_ff, 16'b0} + {37'b0, a_prod_rem_ff};
      if (a_op_ff == REQ_TTF) begin
         // scaled by 2**16 so that both conversions share one quotient length
         nhigh = ttf_num[78:31];
         low   = {ttf_num[30:0], 16'b0};
         d     = tempo;
      end else begin
         nhigh = {32'b0, a_prod_ff[62:47]};
         low   = a_prod_ff[46:0];
         d     = {6'b0, rate60};
      end
      sat = nhigh >= {16'b0, d};

      b_data_in     = '0;
      b_data_in.op  = a_op_ff;
      b_data_in.d   = d;
      b_data_in.r   = nhigh[R_W-1:0];
      b_data_in.sh  = low;
      b_data_in.res = a_res_ff;
      case (a_op_ff)
         REQ_TTF: begin
            if (a_neg_ff) begin
               b_data_in.res.range_flag = 1'b1;
            end else if (sat) begin
               b_data_in.res.frames_out = FRAME_MAX;
               b_data_in.res.range_flag = 1'b1;
            end else begin
               b_data_in.div = 1'b1;
            end
         end
         REQ_FTT: begin
            if (d == '0 && a_prod_ff == '0) begin
               b_data_in.div = 1'b0;
            end else if (sat) begin
               b_data_in.res.res_beats  = BEATS_MAX;
               b_data_in.res.res_rem    = REM_MAX;
               b_data_in.res.range_flag = 1'b1;
            end else begin
               b_data_in.div = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_data_ff <= b_data_in;
      end
   end

   assign head_valid = b_valid_ff;
   assign head       = b_data_ff;

endmodule

[rtl/mtac_div_cell.sv]
// ----------------------------------------------------------------------------
// mtac_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module mtac_div_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  mtac_pkg::cell_data_type  in_data,
   output logic                     out_valid,
   output mtac_pkg::cell_data_type  out_data
);
   import mtac_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff, data_in;
   logic [R_W:0]  r2, r_sub;
   logic          ge;

   always_comb begin
      r2      = {in_data.r, in_data.sh[Q_W-1]};
      r_sub   = r2 - {1'b0, in_data.d};
      ge      = (r2 >= {1'b0, in_data.d});
      data_in    = in_data;
      data_in.r  = ge ? r_sub[R_W-1:0] : r2[R_W-1:0];
      data_in.sh = {in_data.sh[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the musical time arithmetic converter. A scoreboard
// class predicts each result from the accepted request and the current tempo
// and sample rate, and checks the results in order. Tasks drive the request
// and register ports, a loop the result port; random idling, back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mtac_pkg::*;

   class time_scoreboard;
      rsp_item_type        expected_q[$];
      logic [TEMPO_W-1:0]  tempo_fx;
      logic [RATE_W-1:0]   rate;
      int                  errors;

      function new();
         tempo_fx = TEMPO_RESET;
         rate     = 20'd48000;
         errors   = 0;
      endfunction

      function rsp_item_type predict(req_item_type q);
         rsp_item_type  r;
         logic [16:0]   rem_sum;
         logic [127:0]  num, den, quo;
         logic [63:0]   prod, div64, whole;
         r = '0;
         case (q.req_type)
            REQ_CMP: begin
               if ($signed(q.a_beats) < $signed(q.b_beats) ||
                   (q.a_beats == q.b_beats && q.a_rem < q.b_rem))
                  r.order = ORD_LT;
               else if (q.a_beats != q.b_beats || q.a_rem != q.b_rem)
                  r.order = ORD_GT;
            end
            REQ_ADD: begin
               rem_sum     = {1'b0, q.a_rem} + {1'b0, q.b_rem};
               r.res_beats = q.a_beats + q.b_beats + rem_sum[16];
               r.res_rem   = rem_sum[15:0];
            end
            REQ_SUB: begin
               r.res_beats = q.a_beats - q.b_beats - (q.a_rem < q.b_rem);
               r.res_rem   = q.a_rem - q.b_rem;
            end
            REQ_TTF: begin
               if (q.a_beats[31]) begin
                  r.range_flag = 1'b1;
               end else if (tempo_fx == 0) begin
                  r.frames_out = FRAME_MAX;
                  r.range_flag = 1'b1;
               end else begin
                  num = (128'(q.a_beats) << 16) + 128'(q.a_rem);
                  num = num * ((128'(rate) * 128'd60) << 16);
                  den = 128'(tempo_fx) << 16;
                  quo = num / den;
                  if (quo > 128'(FRAME_MAX)) begin
                     r.frames_out = FRAME_MAX;
                     r.range_flag = 1'b1;
                  end else begin
                     r.frames_out = quo[FRAME_W-1:0];
                  end
               end
            end
            REQ_FTT: begin
               prod  = 64'(q.frame_count) * 64'(tempo_fx);
               div64 = (64'(rate) * 64'd60) << 16;
               if (div64 == 0) begin
                  if (prod != 0) begin
                     r.res_beats  = BEATS_MAX;
                     r.res_rem    = REM_MAX;
                     r.range_flag = 1'b1;
                  end
               end else begin
                  whole = prod / div64;
                  if (whole > 64'(BEATS_MAX)) begin
                     r.res_beats  = BEATS_MAX;
                     r.res_rem    = REM_MAX;
                     r.range_flag = 1'b1;
                  end else begin
                     r.res_beats = whole[31:0];
                     r.res_rem   = 16'(((prod % div64) << 16) / div64);
                  end
               end
            end
            default: r = '0;
         endcase
         return r;
      endfunction

      function void note_request(req_item_type q);
         expected_q.push_back(predict(q));
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding: %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.res_beats !== want.res_beats) begin
            $error("res_beats: expected %h, got %h", want.res_beats, got.res_beats);
            errors++;
         end
         if (got.res_rem !== want.res_rem) begin
            $error("res_rem: expected %h, got %h", want.res_rem, got.res_rem);
            errors++;
         end
         if (got.frames_out !== want.frames_out) begin
            $error("frames_out: expected %h, got %h", want.frames_out, got.frames_out);
            errors++;
         end
         if (got.order !== want.order) begin
            $error("order: expected %h, got %h", want.order, got.order);
            errors++;
         end
         if (got.range_flag !== want.range_flag) begin
            $error("range_flag: expected %b, got %b", want.range_flag, got.range_flag);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_item_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_item_type        rsp_data;
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_TEMPO;
   logic [TEMPO_W-1:0]  csr_wdata = '0;

   time_scoreboard      sb = new();
   int                  tx_idle = 0;
   int                  rx_idle = 0;
   int                  rx_hold = 0;

   musical_time_arith_converter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("musical_time_arith_converter: mismatch");
      $finish;
   end

   // result side, with its own long hold-off counter
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   task automatic send_request(req_item_type item);
      if ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [TEMPO_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_TEMPO)
         sb.tempo_fx = value;
      else
         sb.rate = value[RATE_W-1:0];
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_beats();
      case ($urandom_range(4))
         0:       return $urandom();
         1:       return $urandom_range(0, 100000);
         2:       return -$urandom_range(0, 100000);
         3:       return $urandom_range(0, 300);
         default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
   endfunction

   function automatic logic [FRAME_W-1:0] pick_frames();
      case ($urandom_range(3))
         0:       return 31'($urandom());
         1:       return 31'($urandom_range(0, 10000000));
         2:       return 31'($urandom_range(0, 1000));
         default: return $urandom_range(1) ? FRAME_MAX : '0;
      endcase
   endfunction

   function automatic req_item_type random_request();
      req_item_type q;
      q.req_type    = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
      q.a_beats     = pick_beats();
      q.a_rem       = 16'($urandom());
      q.b_beats     = ($urandom_range(3) == 0) ? q.a_beats : pick_beats();
      q.b_rem       = ($urandom_range(3) == 0) ? q.a_rem : 16'($urandom());
      q.frame_count = pick_frames();
      return q;
   endfunction

   function automatic req_item_type make_req(logic [2:0] op, logic [31:0] ab,
                                             logic [15:0] ar, logic [31:0] bb,
                                             logic [15:0] br, logic [30:0] fc);
      req_item_type q;
      q = '{op, ab, ar, bb, br, fc};
      return q;
   endfunction

   initial begin
      req_item_type directed[$];
      logic [TEMPO_W-1:0] tempo_set[6];
      logic [TEMPO_W-1:0] rate_set[6];

      tempo_set = '{TEMPO_RESET, 32'd1, 32'hFFFF_FFFF, 32'd0, TEMPO_RESET, $urandom()};
      rate_set  = '{32'd48000, 32'd1, 32'h000F_FFFF, 32'd48000, 32'd0,
                    32'($urandom_range(1, 1048575))};

      directed = '{
         make_req(REQ_CMP, 32'd5, 16'd1, 32'd5, 16'd1, '0),
         make_req(REQ_CMP, 32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF, 16'd0, '0),
         make_req(REQ_CMP, 32'h7FFF_FFFF, 16'd0, 32'h8000_0000, 16'hFFFF, '0),
         make_req(REQ_CMP, 32'd3, 16'd2, 32'd3, 16'd9, '0),
         make_req(REQ_ADD, 32'h7FFF_FFFF, 16'hFFFF, 32'd0, 16'd1, '0),
         make_req(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '0),
         make_req(REQ_ADD, 32'd0, 16'd0, 32'd0, 16'd0, '0),
         make_req(REQ_SUB, 32'h8000_0000, 16'd0, 32'd0, 16'd1, '0),
         make_req(REQ_SUB, 32'd10, 16'hFFFF, 32'd3, 16'd0, '0),
         make_req(REQ_SUB, 32'd0, 16'd0, 32'h8000_0000, 16'hFFFF, '0),
         make_req(REQ_TTF, 32'd0, 16'd0, '0, '0, '0),
         make_req(REQ_TTF, 32'd1, 16'd0, '0, '0, '0),
         make_req(REQ_TTF, 32'd0, 16'hFFFF, '0, '0, '0),
         make_req(REQ_TTF, 32'hFFFF_FFFF, 16'd5, '0, '0, '0),
         make_req(REQ_TTF, 32'h7FFF_FFFF, 16'hFFFF, '0, '0, '0),
         make_req(REQ_TTF, 32'd89478, 16'd0, '0, '0, '0),
         make_req(REQ_FTT, '0, '0, '0, '0, 31'd0),
         make_req(REQ_FTT, '0, '0, '0, '0, 31'd1),
         make_req(REQ_FTT, '0, '0, '0, '0, 31'd24000),
         make_req(REQ_FTT, '0, '0, '0, '0, FRAME_MAX),
         make_req(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, FRAME_MAX),
         make_req(3'd7, 32'd1, 16'd1, 32'd1, 16'd1, 31'd1)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k])
         send_request(directed[k]);

      for (int phase = 0; phase < 6; phase++) begin
         if (phase != 0) begin
            wait_drained();
            write_reg(CSR_TEMPO, tempo_set[phase]);
            write_reg(CSR_RATE, rate_set[phase]);
         end
         case (phase % 3)
            0: begin tx_idle = 32; rx_idle = 76; end
            1: begin tx_idle = 76; rx_idle = 32; end
            default: begin tx_idle = 0; rx_idle = 0; end
         endcase
         for (int n = 0; n < 170; n++) begin
            // let the row fill up behind a stalled result
            if (phase == 2 && n == 40)
               rx_hold = 300;
            if (phase == 1 && n == 40)
               wait_drained();
            send_request(random_request());
         end
      end

      wait_drained();
      if (sb.errors == 0)
         $display("musical_time_arith_converter: match");
      else
         $display("musical_time_arith_converter: mismatch");
      $finish;
   end

endmodule
